@@ design/aip_pkg.sv @@
`timescale 1ns / 1ps
// aip_pkg: types, codes and small helper functions of the ascii integer parser
// used by aip_step, aip_fmt and ascii_integer_parser_top; no dependencies
package aip_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_MODE   = 2'd1;
    localparam logic [1:0] CFG_SIGNED = 2'd2;
    localparam logic [1:0] CFG_WIDTH  = 2'd3;

    // base codes
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    // parse modes
    localparam logic [1:0] MODE_STOP        = 2'd0;
    localparam logic [1:0] MODE_STRICT      = 2'd1;
    localparam logic [1:0] MODE_TRIM_STOP   = 2'd2;
    localparam logic [1:0] MODE_TRIM_STRICT = 2'd3;

    // width codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    // parse phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_SIGNONLY = 3'd2;
    localparam logic [2:0] ST_BADDIGIT = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam logic [4:0] DIGIT_NONE = 5'h1F;

    // range maximum divided by ten, index {signed_mode, width_code}
    localparam logic [63:0] DIV10_LIMIT [8] = '{
        64'd25,
        64'd6553,
        64'd429496729,
        64'd1844674407370955161,
        64'd12,
        64'd3276,
        64'd214748364,
        64'd922337203685477580
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty_string;
    } char_t;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic [1:0] base_code;
        logic [1:0] mode_sel;
        logic       signed_mode;
        logic [1:0] width_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [63:0] magnitude;
        logic        negative;
        logic [2:0]  error_code;
        logic [1:0]  position;
        logic        stopped;
        logic        pending_ws;
    } pstate_t;

    // finished parse handed to the formatter
    typedef struct packed {
        logic [63:0] magnitude;
        logic        negative;
        logic [2:0]  status;
        logic        signed_mode;
        logic [1:0]  width_code;
    } raw_t;

    localparam pstate_t PSTATE_CLEAR = '{
        phase:      PH_START,
        magnitude:  64'd0,
        negative:   1'b0,
        error_code: ST_OK,
        position:   2'd0,
        stopped:    1'b0,
        pending_ws: 1'b0
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h0A) || (c == 8'h09) ||
               (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // digit value in the given base, DIGIT_NONE when not a digit of it
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] base);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'hFF;
        if (c >= 8'h30 && c <= 8'h39)
            d = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            d = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46)
            d = c - 8'h37;
        r = DIGIT_NONE;
        unique case (base)
            BASE_BIN: if (d < 8'd2)  r = d[4:0];
            BASE_OCT: if (d < 8'd8)  r = d[4:0];
            BASE_DEC: if (d < 8'd10) r = d[4:0];
            BASE_HEX: if (d < 8'd16) r = d[4:0];
            default:  r = DIGIT_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] range_max(input logic [1:0] wc, input logic sgn);
        logic [63:0] m;
        unique case (wc)
            WIDTH_8:  m = 64'h0000_0000_0000_00FF;
            WIDTH_16: m = 64'h0000_0000_0000_FFFF;
            WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
            WIDTH_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:  m = 64'h0000_0000_FFFF_FFFF;
        endcase
        return sgn ? (m >> 1) : m;
    endfunction

endpackage

@@ design/ascii_integer_parser_top.sv @@
`timescale 1ns / 1ps
// ascii_integer_parser_top: streaming ascii to integer parser, top level
// depends on aip_pkg, aip_step, aip_fmt
//
//  channel   direction  handshake                  beat
//  char      in         char_valid / char_ready    one character, last, empty_string
//  result    out        result_valid/result_ready  value and status of one string
//  cfg       in         cfg_we (write only)        cfg_index, cfg_wdata
//
// one character per cycle sustained unless a closing beat waits on the format
// register; the magnitude update (base shift-add and overflow compare) loops
// through the parse state; a result passes the input register, the parse step
// into the format register and the formatter into the output register
// reset clears the parse state, the pipeline valid bits and the registers
// to base 10, mode 0, signed, 32-bit
// a stalled result holds only the stages behind it that carry results;
// characters that end no string keep flowing while a result waits
module ascii_integer_parser_top
    import aip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_t      char_data,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_wdata
);

    cfg_t    cfg_reg;

    // input register
    logic    s1_valid_reg;
    char_t   s1_data_reg;

    // parse state
    pstate_t state_reg;
    pstate_t state_next;

    // finished parse waiting for format
    logic    s2_valid_reg;
    raw_t    s2_raw_reg;

    // output register
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    emit;
    raw_t    raw;
    result_t fmt_res;
    logic    out_free;
    logic    s2_free;
    logic    s1_adv;
    logic    s2_move;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_code   <= BASE_DEC;
            cfg_reg.mode_sel    <= MODE_STOP;
            cfg_reg.signed_mode <= 1'b1;
            cfg_reg.width_code  <= WIDTH_32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE:   cfg_reg.base_code   <= cfg_wdata;
                CFG_MODE:   cfg_reg.mode_sel    <= cfg_wdata;
                CFG_SIGNED: cfg_reg.signed_mode <= cfg_wdata[0];
                CFG_WIDTH:  cfg_reg.width_code  <= cfg_wdata;
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    aip_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .item       (s1_data_reg),
        .state_next (state_next),
        .emit       (emit),
        .raw        (raw)
    );

    aip_fmt u_fmt (
        .raw (s2_raw_reg),
        .res (fmt_res)
    );

    // handshake chain, back to front
    assign out_free   = !out_valid_reg || result_ready;
    assign s2_move    = s2_valid_reg && out_free;
    assign s2_free    = !s2_valid_reg || out_free;
    // beats that end no string never wait for the result side
    assign s1_adv     = s1_valid_reg && (!emit || s2_free);
    assign char_ready = !s1_valid_reg || s1_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (char_ready)
            s1_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            s1_data_reg <= char_data;
    end

    // parse state advances with each beat leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PSTATE_CLEAR;
        else if (s1_adv)
            state_reg <= state_next;
    end

    // format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv && emit)
            s2_valid_reg <= 1'b1;
        else if (s2_move)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
            s2_raw_reg <= raw;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_move)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
            out_data_reg <= fmt_res;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

`ifndef ASSERT_OFF
    // a failed parse always reports zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != ST_OK |-> result_data.value == 64'd0)
        else $error("nonzero value with error status");

    // status stays within its defined codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.status <= ST_OVERFLOW)
        else $error("undefined status code");

    // closing a string leaves the parse state clear
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && emit |=> state_reg == PSTATE_CLEAR)
        else $error("parse state not cleared after result");

    // a held beat in the input register does not lose its contents
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input register changed while stalled");

    // the parse state only moves when a beat leaves the input register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(state_reg))
        else $error("parse state moved without a beat");
`endif

endmodule

@@ design/aip_step.sv @@
`timescale 1ns / 1ps
// aip_step: one character of parse work, current state to next state
// depends on aip_pkg
module aip_step
    import aip_pkg::*;
(
    input  cfg_t    cfg,
    input  pstate_t cur,
    input  char_t   item,
    output pstate_t state_next,
    output logic    emit,
    output raw_t    raw
);

    pstate_t     nxt;
    logic        ws;
    logic        take;
    logic        skip;
    logic [4:0]  digit;
    logic [63:0] max_val;
    logic [63:0] limit;
    logic [63:0] scaled;
    logic [2:0]  status;

    assign ws    = is_space(item.ch);
    assign digit = digit_of(item.ch, cfg.base_code);
    assign max_val = range_max(cfg.width_code, cfg.signed_mode);

    // magnitude times base, shifts only plus one add for decimal
    always_comb
    begin
        unique case (cfg.base_code)
            BASE_BIN: scaled = cur.magnitude << 1;
            BASE_OCT: scaled = cur.magnitude << 3;
            BASE_DEC: scaled = (cur.magnitude << 3) + (cur.magnitude << 1);
            BASE_HEX: scaled = cur.magnitude << 4;
            default:  scaled = cur.magnitude;
        endcase
    end

    // largest magnitude that still takes one more digit
    always_comb
    begin
        unique case (cfg.base_code)
            BASE_BIN: limit = max_val >> 1;
            BASE_OCT: limit = max_val >> 3;
            BASE_DEC: limit = DIV10_LIMIT[{cfg.signed_mode, cfg.width_code}];
            BASE_HEX: limit = max_val >> 4;
            default:  limit = max_val;
        endcase
    end

    always_comb
    begin
        nxt  = cur;
        take = 1'b0;
        skip = 1'b0;
        if (!item.empty_string && cur.error_code == ST_OK && !cur.stopped)
        begin
            if (cur.phase == PH_START)
            begin
                if (!(cfg.mode_sel[1] && ws))
                begin
                    if (cfg.signed_mode && (item.ch == CH_PLUS || item.ch == CH_MINUS))
                    begin
                        nxt.negative = (item.ch == CH_MINUS);
                        nxt.phase    = PH_SIGN;
                    end
                    else
                    begin
                        nxt.phase = PH_BODY;
                        take      = 1'b1;
                    end
                end
            end
            else if (cfg.mode_sel == MODE_TRIM_STRICT && ws)
                nxt.pending_ws = 1'b1;
            else if (cfg.mode_sel == MODE_TRIM_STRICT && cur.pending_ws)
                nxt.error_code = ST_BADDIGIT;
            else
            begin
                nxt.phase = PH_BODY;
                take      = 1'b1;
            end
        end

        if (take)
        begin
            if (cur.position != 2'd3)
                nxt.position = cur.position + 2'd1;
            // base prefix: 'b' in binary, "0x" in hex
            skip = (cur.position == 2'd0 && cfg.base_code == BASE_BIN && item.ch == CH_B) ||
                   (cur.position == 2'd1 && cfg.base_code == BASE_HEX &&
                    (item.ch == CH_X_LO || item.ch == CH_X_UP) && cur.magnitude == 64'd0);
            if (!skip)
            begin
                if (digit == DIGIT_NONE)
                begin
                    if (cfg.mode_sel[0])
                        nxt.error_code = ST_BADDIGIT;
                    else
                        nxt.stopped = 1'b1;
                end
                else if (cur.magnitude > limit)
                    nxt.error_code = ST_OVERFLOW;
                else if (64'(digit) > max_val - scaled)
                    nxt.error_code = ST_OVERFLOW;
                else
                    nxt.magnitude = scaled + 64'(digit);
            end
        end
    end

    always_comb
    begin
        if (nxt.error_code != ST_OK)
            status = nxt.error_code;
        else if (nxt.phase == PH_START)
            status = ST_EMPTY;
        else if (nxt.phase == PH_SIGN)
            status = ST_SIGNONLY;
        else
            status = ST_OK;
    end

    assign emit       = item.last || item.empty_string;
    assign state_next = emit ? PSTATE_CLEAR : nxt;

    assign raw.magnitude   = nxt.magnitude;
    assign raw.negative    = nxt.negative;
    assign raw.status      = status;
    assign raw.signed_mode = cfg.signed_mode;
    assign raw.width_code  = cfg.width_code;

endmodule

@@ design/aip_fmt.sv @@
`timescale 1ns / 1ps
// aip_fmt: turns a finished magnitude and sign into the result word
// depends on aip_pkg
module aip_fmt
    import aip_pkg::*;
(
    input  raw_t    raw,
    output result_t res
);

    logic [63:0] v;
    logic [63:0] shaped;

    assign v = raw.negative ? (~raw.magnitude + 64'd1) : raw.magnitude;

    always_comb
    begin
        unique case (raw.width_code)
            WIDTH_8:  shaped = {{56{raw.signed_mode & v[7]}}, v[7:0]};
            WIDTH_16: shaped = {{48{raw.signed_mode & v[15]}}, v[15:0]};
            WIDTH_32: shaped = {{32{raw.signed_mode & v[31]}}, v[31:0]};
            WIDTH_64: shaped = v;
            default:  shaped = v;
        endcase
    end

    assign res.value  = (raw.status == ST_OK) ? shaped : 64'd0;
    assign res.status = raw.status;

endmodule
